// ===== hdl/asws_pkg.sv =====
`default_nettype none
package asws_pkg;

  localparam int SeqW          = 16;
  localparam int SlotW         = 5;
  localparam int MaxWindowDef  = 32;
  localparam int MarkLimit     = 32;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSeqBits = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWinLim  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTotal   = 2'd3;

  localparam logic [4:0] SeqBitsRst = 5'd3;
  localparam logic [5:0] WinLimRst  = 6'd4;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_START,
    OP_ACK,
    OP_TIMEOUT,
    OP_IGNORE
  } op_e;

  typedef enum logic [2:0] {
    RK_SEND     = 3'd0,
    RK_DONE     = 3'd1,
    RK_TIMEOUT  = 3'd2,
    RK_LOST     = 3'd3,
    RK_ALL_SENT = 3'd4,
    RK_IGNORED  = 3'd5
  } rk_e;

  typedef struct packed {
    logic            valid;
    op_e             op;
    logic [SeqW-1:0] ack_seq;
  } head_t;

  // sequence mask for width m clamped to 2..16
  function automatic logic [SeqW-1:0] seq_mask(input logic [4:0] bits);
    logic [4:0]  m;
    logic [16:0] one_hot;
    begin
      m = bits;
      if (m < 5'd2) m = 5'd2;
      if (m > 5'd16) m = 5'd16;
      one_hot = 17'd1 << m;
      seq_mask = 16'(one_hot - 17'd1);
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/asws_if.sv =====
`default_nettype none
interface asws_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [asws_pkg::SeqW-1:0]   ack_seq;

  modport source (output valid, output kind, output ack_seq, input ready);
  modport sink   (input valid, input kind, input ack_seq, output ready);
endinterface

interface asws_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  result_kind;
  logic [asws_pkg::SeqW-1:0]   seq;
  logic [asws_pkg::SlotW-1:0]  slot;
  logic [asws_pkg::SeqW-1:0]   sent_count;
  logic                        last;

  modport source (output valid, output result_kind, output seq, output slot,
                  output sent_count, output last, input ready);
  modport sink   (input valid, input result_kind, input seq, input slot,
                  input sent_count, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/asws_front.sv =====
`default_nettype none
// Accepts events, decodes them into commands and queues them for the back end.
module asws_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  asws_in_if.sink              in_chan_i,
  output asws_pkg::head_t      head_o,
  input  wire logic            pop_i
);

  localparam int Depth = 2;

  asws_pkg::op_e                 op_mem_q  [Depth];
  logic [asws_pkg::SeqW-1:0]     ack_mem_q [Depth];
  logic                          wr_ptr_q, wr_ptr_d;
  logic                          rd_ptr_q, rd_ptr_d;
  logic [1:0]                    cnt_q, cnt_d;
  logic                          push;
  logic                          pop;
  asws_pkg::op_e                 op_dec;

  always_comb begin
    case (asws_pkg::kind_e'(in_chan_i.kind))
      asws_pkg::KIND_START:   op_dec = asws_pkg::OP_START;
      asws_pkg::KIND_ACK:     op_dec = asws_pkg::OP_ACK;
      asws_pkg::KIND_TIMEOUT: op_dec = asws_pkg::OP_TIMEOUT;
      default:                op_dec = asws_pkg::OP_IGNORE;
    endcase
  end

  assign in_chan_i.ready = (cnt_q != 2'(Depth));
  assign push            = in_chan_i.valid && in_chan_i.ready;
  assign pop             = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_mem_q[wr_ptr_q]  <= op_dec;
      ack_mem_q[wr_ptr_q] <= in_chan_i.ack_seq;
    end
  end

  assign head_o.valid   = (cnt_q != 2'd0);
  assign head_o.op      = op_mem_q[rd_ptr_q];
  assign head_o.ack_seq = ack_mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== hdl/asws_back.sv =====
`default_nettype none
// Window state and sequencer: runs one command at a time into the result register.
module asws_back #(
  parameter int MAX_WINDOW = asws_pkg::MaxWindowDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [asws_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [asws_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire asws_pkg::head_t                head_i,
  output logic                                pop_o,
  asws_out_if.source                          out_chan_o
);

  localparam int WinCap = (MAX_WINDOW > asws_pkg::MarkLimit) ? asws_pkg::MarkLimit :
                          MAX_WINDOW;
  localparam int CntW   = $clog2(WinCap + 1);
  localparam int IdxW   = (WinCap > 1) ? $clog2(WinCap) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SEND,
    ST_SCAN
  } state_e;

  state_e                      state_q, state_d;
  logic                        mode_q;
  logic [4:0]                  seq_bits_q;
  logic [5:0]                  win_lim_q;
  logic [15:0]                 total_q;

  logic [15:0]                 base_q, base_d;
  logic [15:0]                 conf_q, conf_d;
  logic [WinCap-1:0]           marks_q, marks_d;
  logic [CntW-1:0]             exp_q, exp_d;
  logic [CntW-1:0]             win_q, win_d;
  logic                        open_q, open_d;
  logic [CntW-1:0]             slot_q, slot_d;
  logic                        first_q, first_d;

  logic                        ov_q, ov_d;
  asws_pkg::rk_e               ok_q, ok_d;
  logic [15:0]                 oseq_q, oseq_d;
  logic [asws_pkg::SlotW-1:0]  oslot_q, oslot_d;
  logic [15:0]                 ocnt_q, ocnt_d;
  logic                        olast_q, olast_d;

  logic [15:0]                 mask;
  logic [15:0]                 left;
  logic [CntW-1:0]             cap;
  logic [CntW-1:0]             new_win;
  logic [WinCap-1:0]           wmask;
  logic [WinCap-1:0]           above;
  logic [WinCap-1:0]           unm;
  logic                        any_above;
  logic                        exp_in;
  logic [15:0]                 want;
  logic [15:0]                 base_adv;
  logic [15:0]                 conf_adv;
  logic                        out_free;

  assign mask     = asws_pkg::seq_mask(seq_bits_q);
  assign left     = (total_q > conf_q) ? (total_q - conf_q) : 16'd0;
  assign out_free = !ov_q || out_chan_o.ready;

  always_comb begin
    if (win_lim_q == 6'd0) begin
      cap = CntW'(1);
    end else if (7'(win_lim_q) > 7'(WinCap)) begin
      cap = CntW'(WinCap);
    end else begin
      cap = CntW'(win_lim_q);
    end
    new_win = (left < 16'(cap)) ? CntW'(left) : cap;
  end

  always_comb begin
    for (int i = 0; i < WinCap; i++) begin
      wmask[i] = (32'(i) < 32'(win_q));
      above[i] = (32'(i) > 32'(slot_q));
    end
  end

  assign unm       = ~marks_q & wmask;
  assign any_above = |(unm & above);
  assign exp_in    = (exp_q < win_q);
  assign want      = (base_q + 16'(exp_q)) & mask;
  assign base_adv  = (base_q + 16'(win_q)) & mask;
  assign conf_adv  = conf_q + 16'(win_q);
  assign pop_o     = (state_q == ST_IDLE) && head_i.valid && out_free;

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    conf_d  = conf_q;
    marks_d = marks_q;
    exp_d   = exp_q;
    win_d   = win_q;
    open_d  = open_q;
    slot_d  = slot_q;
    first_d = first_q;
    ov_d    = ov_q && !out_chan_o.ready;
    ok_d    = ok_q;
    oseq_d  = oseq_q;
    oslot_d = oslot_q;
    ocnt_d  = ocnt_q;
    olast_d = olast_q;

    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          ocnt_d  = conf_q;
          oslot_d = '0;
          oseq_d  = base_q;
          olast_d = 1'b1;
          case (head_i.op)
            asws_pkg::OP_START: begin
              if (left == 16'd0) begin
                open_d = 1'b0;
                ov_d   = 1'b1;
                ok_d   = asws_pkg::RK_ALL_SENT;
              end else begin
                if (marks_q == '0) win_d = new_win;
                state_d = ST_START;
              end
            end
            asws_pkg::OP_ACK, asws_pkg::OP_TIMEOUT: begin
              if (open_q && exp_in) begin
                if (head_i.op == asws_pkg::OP_TIMEOUT || head_i.ack_seq < want) begin
                  open_d  = 1'b0;
                  if (!mode_q) marks_d = '0;
                  ov_d    = 1'b1;
                  ok_d    = (head_i.op == asws_pkg::OP_TIMEOUT) ? asws_pkg::RK_TIMEOUT :
                            asws_pkg::RK_LOST;
                  oseq_d  = want;
                  oslot_d = asws_pkg::SlotW'(exp_q);
                end else begin
                  marks_d[exp_q[IdxW-1:0]] = 1'b1;
                  exp_d   = exp_q + CntW'(1);
                  state_d = ST_SCAN;
                end
              end else begin
                ov_d = 1'b1;
                ok_d = asws_pkg::RK_IGNORED;
              end
            end
            default: begin
              ov_d = 1'b1;
              ok_d = asws_pkg::RK_IGNORED;
            end
          endcase
        end
      end

      ST_START: begin
        if (unm == '0) begin
          if (out_free) begin
            ov_d    = 1'b1;
            ok_d    = asws_pkg::RK_IGNORED;
            oseq_d  = base_q;
            oslot_d = '0;
            ocnt_d  = conf_q;
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          open_d  = 1'b1;
          slot_d  = '0;
          first_d = 1'b1;
          state_d = ST_SEND;
        end
      end

      ST_SEND: begin
        if (!unm[slot_q[IdxW-1:0]]) begin
          slot_d = slot_q + CntW'(1);
        end else if (out_free) begin
          ov_d    = 1'b1;
          ok_d    = asws_pkg::RK_SEND;
          oseq_d  = (base_q + 16'(slot_q)) & mask;
          oslot_d = asws_pkg::SlotW'(slot_q);
          ocnt_d  = conf_q;
          olast_d = !any_above;
          if (first_q) begin
            exp_d   = slot_q;
            first_d = 1'b0;
          end
          if (!any_above) begin
            state_d = ST_IDLE;
          end else begin
            slot_d = slot_q + CntW'(1);
          end
        end
      end

      ST_SCAN: begin
        // skip slots already acked on an earlier round
        if (exp_in && marks_q[exp_q[IdxW-1:0]]) begin
          exp_d = exp_q + CntW'(1);
        end else if (!exp_in) begin
          if (out_free) begin
            base_d  = base_adv;
            conf_d  = conf_adv;
            marks_d = '0;
            exp_d   = '0;
            open_d  = 1'b0;
            ov_d    = 1'b1;
            ok_d    = asws_pkg::RK_DONE;
            oseq_d  = base_adv;
            oslot_d = '0;
            ocnt_d  = conf_adv;
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= 1'b0;
      seq_bits_q <= asws_pkg::SeqBitsRst;
      win_lim_q  <= asws_pkg::WinLimRst;
      total_q    <= 16'd0;
      base_q     <= 16'd0;
      conf_q     <= 16'd0;
      marks_q    <= '0;
      exp_q      <= '0;
      win_q      <= '0;
      open_q     <= 1'b0;
      slot_q     <= '0;
      first_q    <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      conf_q  <= conf_d;
      marks_q <= marks_d;
      exp_q   <= exp_d;
      win_q   <= win_d;
      open_q  <= open_d;
      slot_q  <= slot_d;
      first_q <= first_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          asws_pkg::CfgMode:    mode_q     <= cfg_data_i[0];
          asws_pkg::CfgSeqBits: seq_bits_q <= cfg_data_i[4:0];
          asws_pkg::CfgWinLim:  win_lim_q  <= cfg_data_i[5:0];
          asws_pkg::CfgTotal:   total_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q    <= ok_d;
    oseq_q  <= oseq_d;
    oslot_q <= oslot_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  assign out_chan_o.valid       = ov_q;
  assign out_chan_o.result_kind = ok_q;
  assign out_chan_o.seq         = oseq_q;
  assign out_chan_o.slot        = oslot_q;
  assign out_chan_o.sent_count  = ocnt_q;
  assign out_chan_o.last        = olast_q;

endmodule
`default_nettype wire

// ===== hdl/arq_sliding_window_sender_top.sv =====
`default_nettype none
// Sliding-window ARQ sender controller, go-back-N or selective repeat. Events
// (start, ack, timeout) enter a two-entry command queue and are executed one at
// a time by the window sequencer, whose results go out through a registered
// output stage. A start scans the window slot by slot up to the last unacked
// slot, with one send result per unacked slot, or gives an ignored result when
// every slot is already acked; an ack skips the already-acked slots after it;
// timeouts, losses, all-sent and ignored events give a single result. A stalled
// output holds the sequencer. Configuration writes take effect at once; the user
// must keep them to idle periods, as the block itself does not enforce this.
module arq_sliding_window_sender_top #(
  parameter int MAX_WINDOW = asws_pkg::MaxWindowDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [asws_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [asws_pkg::CfgDataW-1:0]  cfg_data_i,
  asws_in_if.sink                             in_chan_i,
  asws_out_if.source                          out_chan_o
);

  asws_pkg::head_t head;
  logic            pop;

  asws_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan_i (in_chan_i),
    .head_o    (head),
    .pop_i     (pop)
  );

  asws_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .head_i     (head),
    .pop_o      (pop),
    .out_chan_o (out_chan_o)
  );

endmodule
`default_nettype wire
